FILE: rtl/core/lehist_pkg.sv
// Shared types and codes for the line editor with history.
package lehist_pkg;

  // Decoded key events.
  typedef enum logic [2:0] {
    OP_ENTER = 3'd0,
    OP_BACK  = 3'd1,
    OP_DEL   = 3'd2,
    OP_LEFT  = 3'd3,
    OP_RIGHT = 3'd4,
    OP_UP    = 3'd5,
    OP_DOWN  = 3'd6,
    OP_CHAR  = 3'd7
  } op_e;

  // Result beat kinds.
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_RECALL = 2'd2
  } kind_e;

  // Character stores that the copy engine moves between.
  typedef enum logic [1:0] {
    MEM_EDIT  = 2'd0,
    MEM_HIST  = 2'd1,
    MEM_SAVED = 2'd2
  } mem_e;

  // One classified key event as it travels from the front to the back.
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } item_t;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

endpackage

FILE: rtl/core/lehist_front.sv
// Input stage: accepts key event beats, decodes them and queues them for the back end.
module lehist_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [15:0]                s_data_i,
  output lehist_pkg::item_t          item_o,
  output logic                       item_valid_o,
  input  logic                       item_pop_i
);
  import lehist_pkg::*;

  item_t      q_mem [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  item_t      dec;

  // Classify the raw beat into an event record.
  always_comb begin
    dec.op = op_e'(s_data_i[2:0]);
    dec.ch = s_data_i[10:3];
  end

  assign s_ready_o    = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_mem[rp_q];
  assign push         = s_valid_i && s_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  // Queue pointers and fill count.
  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= dec;
    end
  end

endmodule

FILE: rtl/core/lehist_back.sv
// Execution stage: edit line, history ring, saved line and the result stream.
module lehist_back #(
  parameter int LineCapacity = 64,
  parameter int HistoryDepth = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lehist_pkg::item_t  item_i,
  input  logic               item_valid_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lehist_pkg::kind_e  out_kind_o,
  output logic [7:0]         out_char_o,
  output logic [5:0]         out_len_o,
  output logic [5:0]         out_cur_o,
  output logic               out_browse_o,
  output logic [4:0]         out_fill_o,
  output logic               out_last_o
);
  import lehist_pkg::*;

  localparam int LW  = $clog2(LineCapacity);
  localparam int SW  = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int FW  = $clog2(HistoryDepth + 1);
  localparam int HAW = $clog2(HistoryDepth * LineCapacity);
  localparam logic [LW-1:0] MaxChars = LW'(LineCapacity - 1);
  localparam logic [SW-1:0] LastSlot = SW'(HistoryDepth - 1);
  localparam logic [FW-1:0] FullFill = FW'(HistoryDepth);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_COPY      = 4'd1;
  localparam logic [3:0] S_CMP       = 4'd2;
  localparam logic [3:0] S_ENT_LEN   = 4'd3;
  localparam logic [3:0] S_ENT_CHK   = 4'd4;
  localparam logic [3:0] S_ENT_STORE = 4'd5;
  localparam logic [3:0] S_ENT_DONE  = 4'd6;
  localparam logic [3:0] S_DEL_DONE  = 4'd7;
  localparam logic [3:0] S_INS_DONE  = 4'd8;
  localparam logic [3:0] S_UP_SAVED  = 4'd9;
  localparam logic [3:0] S_LOAD      = 4'd10;
  localparam logic [3:0] S_LOAD2     = 4'd11;
  localparam logic [3:0] S_LOAD_DONE = 4'd12;
  localparam logic [3:0] S_STR_RD    = 4'd13;
  localparam logic [3:0] S_STR_WR    = 4'd14;
  localparam logic [3:0] S_STATUS    = 4'd15;

  // Storage.
  logic [7:0]    edit_mem  [LineCapacity];
  logic [7:0]    saved_mem [LineCapacity];
  logic [7:0]    hist_mem  [HistoryDepth * LineCapacity];
  logic [LW-1:0] hlen_mem  [HistoryDepth];
  logic [7:0]    erd_q, srd_q, hrd_q;
  logic [LW-1:0] lrd_q;

  logic [3:0]    state_q, state_d, after_q, after_d;
  logic [LW-1:0] len_q, len_d, cur_q, cur_d, slen_q, slen_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [SW-1:0] wslot_q, wslot_d, bslot_q, bslot_d, hslot_q, hslot_d;
  logic          bact_q, bact_d, svalid_q, svalid_d;
  logic [LW-1:0] cnt_q, cnt_d, raddr_q, raddr_d, waddr_q, waddr_d, wa_q, wa_d;
  logic          up_q, up_d, wrv_q, wrv_d, cmpv_q, cmpv_d, mism_q, mism_d;
  mem_e          src_q, src_d, dst_q, dst_d;
  logic [LW-1:0] ln_q, ln_d, strn_q, strn_d, k_q, k_d;
  kind_e         kind_q, kind_d;
  logic [7:0]    ch_q, ch_d;
  logic          ov_q, ov_d, olast_q, olast_d;
  kind_e         okind_q, okind_d;
  logic [7:0]    ochar_q, ochar_d;

  logic [SW-1:0] newest, oldest, lra;
  logic [FW:0]   old_sum;
  logic [LW-1:0] era;
  logic [HAW-1:0] hra, hwa;
  logic [7:0]    cp_data;
  logic          slot_free;

  function automatic logic [SW-1:0] slot_prev(input logic [SW-1:0] s);
    slot_prev = (s == '0) ? LastSlot : s - SW'(1);
  endfunction

  function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
    slot_next = (s == LastSlot) ? '0 : s + SW'(1);
  endfunction

  function automatic logic [HAW-1:0] haddr(input logic [SW-1:0] s, input logic [LW-1:0] i);
    haddr = HAW'(s) * HAW'(LineCapacity) + HAW'(i);
  endfunction

  // Ring positions of the newest and oldest entries.
  assign newest  = slot_prev(wslot_q);
  assign old_sum = (FW+1)'(wslot_q) + (FW+1)'(HistoryDepth) - (FW+1)'(fill_q);
  assign oldest  = (old_sum >= (FW+1)'(HistoryDepth)) ?
                   SW'(old_sum - (FW+1)'(HistoryDepth)) : SW'(old_sum);

  // Read addresses for each store.
  assign era = (state_q == S_STR_RD || state_q == S_STR_WR) ? k_q : raddr_q;
  assign hra = haddr(hslot_q, raddr_q);
  assign hwa = haddr(hslot_q, wa_q);
  assign lra = (state_q == S_ENT_LEN) ? newest : bslot_q;

  always_comb begin
    case (src_q)
      MEM_HIST:  cp_data = hrd_q;
      MEM_SAVED: cp_data = srd_q;
      default:   cp_data = erd_q;
    endcase
  end

  assign slot_free   = !ov_q || out_ready_i;
  assign item_pop_o  = (state_q == S_IDLE) && item_valid_i;

  // Memory ports: one write and one registered read per store.
  always_ff @(posedge clk_i) begin
    if (wrv_q && dst_q == MEM_EDIT) begin
      edit_mem[wa_q] <= cp_data;
    end else if (state_q == S_INS_DONE) begin
      edit_mem[cur_q] <= ch_q;
    end
    if (wrv_q && dst_q == MEM_SAVED) begin
      saved_mem[wa_q] <= cp_data;
    end
    if (wrv_q && dst_q == MEM_HIST) begin
      hist_mem[hwa] <= cp_data;
    end
    if (state_q == S_ENT_STORE) begin
      hlen_mem[wslot_q] <= len_q;
    end
    erd_q <= edit_mem[era];
    srd_q <= saved_mem[raddr_q];
    hrd_q <= hist_mem[hra];
    lrd_q <= hlen_mem[lra];
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;  after_d  = after_q;
    len_d    = len_q;    cur_d    = cur_q;    slen_d   = slen_q;
    fill_d   = fill_q;   wslot_d  = wslot_q;  bslot_d  = bslot_q;
    hslot_d  = hslot_q;  bact_d   = bact_q;   svalid_d = svalid_q;
    cnt_d    = cnt_q;    raddr_d  = raddr_q;  waddr_d  = waddr_q;
    wa_d     = wa_q;     up_d     = up_q;     wrv_d    = 1'b0;
    cmpv_d   = 1'b0;     mism_d   = mism_q;   src_d    = src_q;
    dst_d    = dst_q;    ln_d     = ln_q;     strn_d   = strn_q;
    k_d      = k_q;      kind_d   = kind_q;   ch_d     = ch_q;
    ov_d     = ov_q && !out_ready_i;
    okind_d  = okind_q;  ochar_d  = ochar_q;  olast_d  = olast_q;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          ch_d    = item_i.ch;
          state_d = S_STATUS;
          raddr_d = '0;
          waddr_d = '0;
          up_d    = 1'b1;
          src_d   = MEM_EDIT;
          dst_d   = MEM_EDIT;
          unique case (item_i.op)
            OP_ENTER: begin
              if (len_q == '0) begin
                state_d = S_ENT_DONE;
              end else if (fill_q == '0) begin
                dst_d   = MEM_HIST;
                hslot_d = wslot_q;
                cnt_d   = len_q;
                after_d = S_ENT_STORE;
                state_d = S_COPY;
              end else begin
                state_d = S_ENT_LEN;
              end
            end
            OP_BACK: begin
              if (cur_q != '0) begin
                cur_d   = cur_q - LW'(1);
                raddr_d = cur_q;
                waddr_d = cur_q - LW'(1);
                cnt_d   = len_q - cur_q;
                after_d = S_DEL_DONE;
                state_d = S_COPY;
              end
            end
            OP_DEL: begin
              if (cur_q != len_q) begin
                raddr_d = cur_q + LW'(1);
                waddr_d = cur_q;
                cnt_d   = len_q - cur_q - LW'(1);
                after_d = S_DEL_DONE;
                state_d = S_COPY;
              end
            end
            OP_LEFT: begin
              if (cur_q != '0) cur_d = cur_q - LW'(1);
            end
            OP_RIGHT: begin
              if (cur_q != len_q) cur_d = cur_q + LW'(1);
            end
            OP_UP: begin
              if (fill_q != '0) begin
                if (!bact_q) begin
                  dst_d   = MEM_SAVED;
                  cnt_d   = len_q;
                  after_d = S_UP_SAVED;
                  state_d = S_COPY;
                end else begin
                  if (bslot_q != oldest) bslot_d = slot_prev(bslot_q);
                  state_d = S_LOAD;
                end
              end
            end
            OP_DOWN: begin
              if (fill_q != '0 && bact_q) begin
                if (bslot_q == newest) begin
                  bact_d = 1'b0;
                  if (svalid_q) begin
                    src_d   = MEM_SAVED;
                    cnt_d   = slen_q;
                    ln_d    = slen_q;
                    after_d = S_LOAD_DONE;
                    state_d = S_COPY;
                  end else begin
                    len_d = '0;
                    cur_d = '0;
                  end
                end else begin
                  bslot_d = slot_next(bslot_q);
                  state_d = S_LOAD;
                end
              end
            end
            OP_CHAR: begin
              if (len_q != MaxChars) begin
                raddr_d = len_q - LW'(1);
                waddr_d = len_q;
                up_d    = 1'b0;
                cnt_d   = len_q - cur_q;
                after_d = S_INS_DONE;
                state_d = S_COPY;
              end
            end
            default: state_d = S_STATUS;
          endcase
        end
      end
      // Move one character per cycle; drain the last write before leaving.
      S_COPY: begin
        if (cnt_q != '0) begin
          wrv_d   = 1'b1;
          wa_d    = waddr_q;
          raddr_d = up_q ? raddr_q + LW'(1) : raddr_q - LW'(1);
          waddr_d = up_q ? waddr_q + LW'(1) : waddr_q - LW'(1);
          cnt_d   = cnt_q - LW'(1);
        end else if (!wrv_q) begin
          state_d = after_q;
        end
      end
      // Compare the edit line with the newest entry, one character per cycle.
      S_CMP: begin
        if (cmpv_q && erd_q != hrd_q) mism_d = 1'b1;
        if (cnt_q != '0) begin
          cmpv_d  = 1'b1;
          raddr_d = raddr_q + LW'(1);
          cnt_d   = cnt_q - LW'(1);
        end else if (!cmpv_q) begin
          if (mism_d) begin
            src_d   = MEM_EDIT;
            dst_d   = MEM_HIST;
            hslot_d = wslot_q;
            raddr_d = '0;
            waddr_d = '0;
            up_d    = 1'b1;
            cnt_d   = len_q;
            after_d = S_ENT_STORE;
            state_d = S_COPY;
          end else begin
            state_d = S_ENT_DONE;
          end
        end
      end
      S_ENT_LEN: state_d = S_ENT_CHK;
      S_ENT_CHK: begin
        raddr_d = '0;
        waddr_d = '0;
        up_d    = 1'b1;
        cnt_d   = len_q;
        if (lrd_q == len_q) begin
          hslot_d = newest;
          mism_d  = 1'b0;
          state_d = S_CMP;
        end else begin
          src_d   = MEM_EDIT;
          dst_d   = MEM_HIST;
          hslot_d = wslot_q;
          after_d = S_ENT_STORE;
          state_d = S_COPY;
        end
      end
      S_ENT_STORE: begin
        wslot_d = slot_next(wslot_q);
        if (fill_q != FullFill) fill_d = fill_q + FW'(1);
        state_d = S_ENT_DONE;
      end
      S_ENT_DONE: begin
        strn_d   = len_q;
        kind_d   = KIND_COMMIT;
        k_d      = '0;
        len_d    = '0;
        cur_d    = '0;
        bact_d   = 1'b0;
        svalid_d = 1'b0;
        state_d  = S_STR_RD;
      end
      S_DEL_DONE: begin
        len_d   = len_q - LW'(1);
        state_d = S_STATUS;
      end
      S_INS_DONE: begin
        len_d   = len_q + LW'(1);
        cur_d   = cur_q + LW'(1);
        state_d = S_STATUS;
      end
      S_UP_SAVED: begin
        slen_d   = len_q;
        svalid_d = 1'b1;
        bslot_d  = newest;
        bact_d   = 1'b1;
        state_d  = S_LOAD;
      end
      S_LOAD: state_d = S_LOAD2;
      S_LOAD2: begin
        src_d   = MEM_HIST;
        dst_d   = MEM_EDIT;
        hslot_d = bslot_q;
        raddr_d = '0;
        waddr_d = '0;
        up_d    = 1'b1;
        cnt_d   = lrd_q;
        ln_d    = lrd_q;
        after_d = S_LOAD_DONE;
        state_d = S_COPY;
      end
      S_LOAD_DONE: begin
        len_d   = ln_q;
        cur_d   = ln_q;
        strn_d  = ln_q;
        kind_d  = KIND_RECALL;
        k_d     = '0;
        state_d = S_STR_RD;
      end
      // Stream the line, then the status beat.
      S_STR_RD: begin
        state_d = (k_q == strn_q) ? S_STATUS : S_STR_WR;
      end
      S_STR_WR: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          okind_d = kind_q;
          ochar_d = erd_q;
          olast_d = 1'b0;
          k_d     = k_q + LW'(1);
          state_d = S_STR_RD;
        end
      end
      S_STATUS: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_STATUS;
          ochar_d = 8'd0;
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;   after_q <= S_IDLE;
      len_q   <= '0;       cur_q   <= '0;       slen_q   <= '0;
      fill_q  <= '0;       wslot_q <= '0;       bslot_q  <= '0;
      hslot_q <= '0;       bact_q  <= 1'b0;     svalid_q <= 1'b0;
      cnt_q   <= '0;       raddr_q <= '0;       waddr_q  <= '0;
      wa_q    <= '0;       up_q    <= 1'b1;     wrv_q    <= 1'b0;
      cmpv_q  <= 1'b0;     mism_q  <= 1'b0;     src_q    <= MEM_EDIT;
      dst_q   <= MEM_EDIT; ln_q    <= '0;       strn_q   <= '0;
      k_q     <= '0;       kind_q  <= KIND_STATUS;
      ch_q    <= 8'd0;     ov_q    <= 1'b0;     okind_q  <= KIND_STATUS;
      ochar_q <= 8'd0;     olast_q <= 1'b0;
    end else begin
      state_q <= state_d;  after_q <= after_d;
      len_q   <= len_d;    cur_q   <= cur_d;    slen_q   <= slen_d;
      fill_q  <= fill_d;   wslot_q <= wslot_d;  bslot_q  <= bslot_d;
      hslot_q <= hslot_d;  bact_q  <= bact_d;   svalid_q <= svalid_d;
      cnt_q   <= cnt_d;    raddr_q <= raddr_d;  waddr_q  <= waddr_d;
      wa_q    <= wa_d;     up_q    <= up_d;     wrv_q    <= wrv_d;
      cmpv_q  <= cmpv_d;   mism_q  <= mism_d;   src_q    <= src_d;
      dst_q   <= dst_d;    ln_q    <= ln_d;     strn_q   <= strn_d;
      k_q     <= k_d;      kind_q  <= kind_d;
      ch_q    <= ch_d;     ov_q    <= ov_d;     okind_q  <= okind_d;
      ochar_q <= ochar_d;  olast_q <= olast_d;
    end
  end

  // Output register; scalar state is final whenever a beat is loaded.
  logic [5:0] olen_q, ocur_q;
  logic [4:0] ofill_q;
  logic       obr_q;

  always_ff @(posedge clk_i) begin
    if (slot_free && (state_q == S_STR_WR || state_q == S_STATUS)) begin
      olen_q  <= 6'(len_q);
      ocur_q  <= 6'(cur_q);
      ofill_q <= 5'(fill_q);
      obr_q   <= bact_q;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_kind_o   = okind_q;
  assign out_char_o   = ochar_q;
  assign out_len_o    = olen_q;
  assign out_cur_o    = ocur_q;
  assign out_browse_o = obr_q;
  assign out_fill_o   = ofill_q;
  assign out_last_o   = olast_q;

endmodule

FILE: rtl/core/line_editor_with_history.sv
// Top level of the console line editor with a history ring.
//
// Key events enter on the slave stream: tdata holds the operation code in the
// low bits and the character byte above it. Each event produces zero or more
// character beats (committed line on enter, recalled line on up or down)
// followed by one status beat marked by tlast; tuser gives the beat kind.
// The front queue holds two events and stalls the sender only when it is full.
// The back end handles one event at a time and moves one character per cycle
// through a shared copy/compare engine. A line holds at most LINE_CAPACITY - 1
// characters, and each character beat of a streamed line is read from the edit
// line and then loaded into the output register in separate states.
// Reset empties the queue, the edit line and the ring; no clearing pass is
// needed. When the receiver holds tready low, the output register keeps its
// beat and the back end waits; the front keeps taking events until full.
module line_editor_with_history #(
  parameter int LINE_CAPACITY = 64,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [2:0] operation, [10:3] char_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] out_char, [13:8] line_length,
                                        // [19:14] cursor_pos, [20] browsing,
                                        // [25:21] entries_held
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o
);
  import lehist_pkg::*;

  item_t      item;
  logic       item_valid, item_pop;
  kind_e      okind;
  logic [7:0] ochar;
  logic [5:0] olen, ocur;
  logic       obr, olast;
  logic [4:0] ofill;

  lehist_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_data_i     (s_axis_tdata_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  lehist_back #(
    .LineCapacity (LINE_CAPACITY),
    .HistoryDepth (HISTORY_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_kind_o   (okind),
    .out_char_o   (ochar),
    .out_len_o    (olen),
    .out_cur_o    (ocur),
    .out_browse_o (obr),
    .out_fill_o   (ofill),
    .out_last_o   (olast)
  );

  assign m_axis_tdata_o = {6'd0, ofill, obr, ocur, olen, ochar};
  assign m_axis_tuser_o = okind;
  assign m_axis_tlast_o = olast;

  // The cursor never passes the end of the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (ocur <= olen))
    else $error("cursor beyond line length");

  // The closing beat of an event is a status beat with a zero character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && olast) |-> (okind == KIND_STATUS && ochar == 8'd0))
    else $error("last beat is not a status beat");

  // Character beats never carry the status kind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !olast) |-> (okind == KIND_COMMIT || okind == KIND_RECALL))
    else $error("character beat with status kind");

endmodule
